[hw/rtl/id3_pkg.sv]
// Shared types and constants for the ID3v2 frame header parser.
// No dependencies; used by id3_walker and id3v2_frame_header_parser_top.
package id3_pkg;

  // parse phase, one-hot
  typedef enum logic [8:0] {
    P_SIG   = 9'b000000001,
    P_VER   = 9'b000000010,
    P_FLAGS = 9'b000000100,
    P_TSIZE = 9'b000001000,
    P_XSIZE = 9'b000010000,
    P_XSKIP = 9'b000100000,
    P_HDR   = 9'b001000000,
    P_PAY   = 9'b010000000,
    P_DONE  = 9'b100000000
  } phase_t;

  typedef enum logic [2:0] {
    K_DESC = 3'd0,
    K_BYTE = 3'd1,
    K_END  = 3'd2,
    K_PAD  = 3'd3,
    K_ERR  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    E_NONE      = 3'd0,
    E_SIGNATURE = 3'd1,
    E_VERSION   = 3'd2,
    E_FLAGS     = 3'd3,
    E_SIZE      = 3'd4,
    E_ID        = 3'd5,
    E_TRUNCATED = 3'd6
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] id;
    logic [31:0] size;
    logic [15:0] flags;
    logic [7:0]  pbyte;
    logic        last;
    logic [2:0]  version;
    err_t        err;
  } res_t;

  localparam int DATA_W     = 8;
  localparam int OUT_DATA_W = 96;
  localparam int KIND_W     = 3;

  localparam logic [7:0] SYNCHSAFE_LIM = 8'h80;
  localparam logic [7:0] MASK_V2       = 8'h80;
  localparam logic [7:0] MASK_V3       = 8'hE0;
  localparam logic [7:0] MASK_V4       = 8'hF0;
  localparam logic [7:0] FLAG_EXTHDR   = 8'h40;
  localparam logic [7:0] ID_PAD_CHAR   = 8'h20;

  localparam logic [2:0] VER_MIN = 3'd2;
  localparam logic [2:0] VER_V3  = 3'd3;
  localparam logic [2:0] VER_MAX = 3'd4;

  localparam logic [3:0] ID_LEN_V2  = 4'd3;
  localparam logic [3:0] ID_LEN_V3  = 4'd4;
  localparam logic [3:0] HDR_LEN_V2 = 4'd6;
  localparam logic [3:0] HDR_LEN_V3 = 4'd10;
  localparam logic [3:0] SIZE_BYTES = 4'd4;
  localparam logic [3:0] SIG_LEN    = 4'd3;

  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0:    r = 8'h49;  // 'I'
      2'd1:    r = 8'h44;  // 'D'
      2'd2:    r = 8'h33;  // '3'
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic res_t make_res(input kind_t kind, input logic [31:0] id,
                                    input logic [31:0] size, input logic [15:0] flags,
                                    input logic [7:0] pbyte, input logic last,
                                    input logic [2:0] version, input err_t err);
    res_t r;
    r.kind    = kind;
    r.id      = id;
    r.size    = size;
    r.flags   = flags;
    r.pbyte   = pbyte;
    r.last    = last;
    r.version = version;
    r.err     = err;
    return r;
  endfunction

endpackage

[hw/rtl/id3_walker.sv]
// Tag walker: parse state and the per-byte step logic for one byte.
// Depends on id3_pkg (phase, result types, constants).
module id3_walker (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,       // process in_byte/in_end this cycle
  input  logic [7:0]        in_byte,
  input  logic              in_end,
  output logic              res_valid,
  output id3_pkg::res_t     res
);

  id3_pkg::phase_t phase, phase_next;
  logic [3:0]  byte_index, byte_index_next;
  logic [2:0]  version_reg, version_reg_next;
  logic [7:0]  tag_flags, tag_flags_next;
  logic [27:0] tag_size, tag_size_next;
  logic [31:0] consumed, consumed_next;
  logic [31:0] id_shift, id_shift_next;
  logic [31:0] size_shift, size_shift_next;
  logic [15:0] flag_shift, flag_shift_next;
  logic [31:0] remaining, remaining_next;

  logic        v2, v4;
  logic [7:0]  mask;
  logic [3:0]  bi_inc, id_len, hdr_len;
  logic [31:0] id_n, size_n, id_full, rem_sh, rem_adj, xtotal, rem_dec;
  logic [15:0] flags_n;
  logic [32:0] xtotal_w;
  logic [33:0] cons_sum;
  logic        tag_done;

  always_comb begin
    phase_next       = phase;
    byte_index_next  = byte_index;
    version_reg_next = version_reg;
    tag_flags_next   = tag_flags;
    tag_size_next    = tag_size;
    consumed_next    = consumed;
    id_shift_next    = id_shift;
    size_shift_next  = size_shift;
    flag_shift_next  = flag_shift;
    remaining_next   = remaining;
    res_valid        = 1'b0;
    res              = '0;

    v2      = (version_reg == id3_pkg::VER_MIN);
    v4      = (version_reg == id3_pkg::VER_MAX);
    mask    = v2 ? id3_pkg::MASK_V2 : (v4 ? id3_pkg::MASK_V4 : id3_pkg::MASK_V3);
    bi_inc  = byte_index + 4'd1;
    id_len  = v2 ? id3_pkg::ID_LEN_V2 : id3_pkg::ID_LEN_V3;
    hdr_len = v2 ? id3_pkg::HDR_LEN_V2 : id3_pkg::HDR_LEN_V3;

    // header collectors
    id_n    = id_shift;
    size_n  = size_shift;
    flags_n = flag_shift;
    if (byte_index < id_len) begin
      id_n = {id_shift[23:0], in_byte};
    end else if (byte_index < (id_len << 1)) begin
      size_n = v4 ? {size_shift[24:0], in_byte[6:0]} : {size_shift[23:0], in_byte};
    end else begin
      flags_n = {flag_shift[7:0], in_byte};
    end
    if (v2) begin
      id_full = (id_n != '0) ? {id_n[23:0], id3_pkg::ID_PAD_CHAR} : '0;
    end else begin
      id_full = id_n;
    end
    cons_sum = {2'b00, consumed} + {30'd0, hdr_len} + {2'b00, size_n};

    // extended header size
    rem_sh   = v4 ? {remaining[24:0], in_byte[6:0]} : {remaining[23:0], in_byte};
    rem_adj  = (v4 && rem_sh <= 32'd4) ? '0 : (v4 ? rem_sh - 32'd4 : rem_sh);
    xtotal_w = {1'b0, rem_adj} + 33'd4;
    xtotal   = xtotal_w[32] ? '1 : xtotal_w[31:0];
    rem_dec  = remaining - 32'd1;

    tag_done = (phase == id3_pkg::P_HDR) && (byte_index == '0)
               && (consumed >= {4'd0, tag_size});

    if (tag_done) begin
      res_valid   = 1'b1;
      res         = id3_pkg::make_res(id3_pkg::K_END, '0, '0, '0, '0, 1'b0,
                                      version_reg, id3_pkg::E_NONE);
      phase_next  = id3_pkg::P_DONE;
    end else if (in_end) begin
      if (!(phase == id3_pkg::P_DONE || (phase == id3_pkg::P_SIG && byte_index == '0))) begin
        res_valid = 1'b1;
        res       = id3_pkg::make_res(id3_pkg::K_ERR, '0, '0, '0, '0, 1'b0,
                                      version_reg, id3_pkg::E_TRUNCATED);
      end
    end else begin
      unique case (phase)
        id3_pkg::P_SIG: begin
          if (byte_index > 4'd2 || in_byte != id3_pkg::sig_byte(byte_index[1:0])) begin
            res_valid  = 1'b1;
            res        = id3_pkg::make_res(id3_pkg::K_ERR, '0, '0, '0, '0, 1'b0,
                                           version_reg, id3_pkg::E_SIGNATURE);
            phase_next = id3_pkg::P_DONE;
          end else if (bi_inc == id3_pkg::SIG_LEN) begin
            phase_next      = id3_pkg::P_VER;
            byte_index_next = '0;
          end else begin
            byte_index_next = bi_inc;
          end
        end
        id3_pkg::P_VER: begin
          if (byte_index == '0) begin
            if (in_byte < {5'd0, id3_pkg::VER_MIN} || in_byte > {5'd0, id3_pkg::VER_MAX}) begin
              res_valid  = 1'b1;
              res        = id3_pkg::make_res(id3_pkg::K_ERR, '0, '0, '0, '0, 1'b0,
                                             version_reg, id3_pkg::E_VERSION);
              phase_next = id3_pkg::P_DONE;
            end else begin
              version_reg_next = in_byte[2:0];
              byte_index_next  = 4'd1;
            end
          end else begin
            // revision byte, any value
            phase_next      = id3_pkg::P_FLAGS;
            byte_index_next = '0;
          end
        end
        id3_pkg::P_FLAGS: begin
          if ((in_byte & ~mask) != '0) begin
            res_valid  = 1'b1;
            res        = id3_pkg::make_res(id3_pkg::K_ERR, '0, '0, '0, '0, 1'b0,
                                           version_reg, id3_pkg::E_FLAGS);
            phase_next = id3_pkg::P_DONE;
          end else begin
            tag_flags_next  = in_byte;
            phase_next      = id3_pkg::P_TSIZE;
            byte_index_next = '0;
          end
        end
        id3_pkg::P_TSIZE: begin
          if (in_byte >= id3_pkg::SYNCHSAFE_LIM) begin
            res_valid  = 1'b1;
            res        = id3_pkg::make_res(id3_pkg::K_ERR, '0, '0, '0, '0, 1'b0,
                                           version_reg, id3_pkg::E_SIZE);
            phase_next = id3_pkg::P_DONE;
          end else begin
            tag_size_next = {tag_size[20:0], in_byte[6:0]};
            if (bi_inc == id3_pkg::SIZE_BYTES) begin
              byte_index_next = '0;
              consumed_next   = '0;
              remaining_next  = '0;
              phase_next      = ((tag_flags & id3_pkg::FLAG_EXTHDR) != '0)
                                ? id3_pkg::P_XSIZE : id3_pkg::P_HDR;
            end else begin
              byte_index_next = bi_inc;
            end
          end
        end
        id3_pkg::P_XSIZE: begin
          if (v4 && in_byte >= id3_pkg::SYNCHSAFE_LIM) begin
            res_valid  = 1'b1;
            res        = id3_pkg::make_res(id3_pkg::K_ERR, '0, '0, '0, '0, 1'b0,
                                           version_reg, id3_pkg::E_SIZE);
            phase_next = id3_pkg::P_DONE;
          end else if (bi_inc == id3_pkg::SIZE_BYTES) begin
            // whole extended header comes off the tag size, floor at zero
            byte_index_next = '0;
            remaining_next  = rem_adj;
            tag_size_next   = ({4'd0, tag_size} > xtotal)
                              ? tag_size - xtotal[27:0] : '0;
            phase_next      = (rem_adj != '0) ? id3_pkg::P_XSKIP : id3_pkg::P_HDR;
          end else begin
            remaining_next  = rem_sh;
            byte_index_next = bi_inc;
          end
        end
        id3_pkg::P_XSKIP: begin
          remaining_next = rem_dec;
          if (rem_dec == '0) begin
            phase_next = id3_pkg::P_HDR;
          end
        end
        id3_pkg::P_HDR: begin
          id_shift_next   = id_n;
          size_shift_next = size_n;
          flag_shift_next = flags_n;
          byte_index_next = bi_inc;
          // a zero id means padding even with a bad size byte
          if (v4 && byte_index >= id_len && byte_index < (id_len << 1)
              && in_byte >= id3_pkg::SYNCHSAFE_LIM && id_shift != '0) begin
            res_valid  = 1'b1;
            res        = id3_pkg::make_res(id3_pkg::K_ERR, '0, '0, '0, '0, 1'b0,
                                           version_reg, id3_pkg::E_SIZE);
            phase_next = id3_pkg::P_DONE;
          end else if (bi_inc == hdr_len) begin
            byte_index_next = '0;
            res_valid       = 1'b1;
            priority if (id_full == '0) begin
              res        = id3_pkg::make_res(id3_pkg::K_PAD, '0, '0, '0, '0, 1'b0,
                                             version_reg, id3_pkg::E_NONE);
              phase_next = id3_pkg::P_DONE;
            end else if (size_n == '0) begin
              res        = id3_pkg::make_res(id3_pkg::K_ERR, '0, '0, '0, '0, 1'b0,
                                             version_reg, id3_pkg::E_SIZE);
              phase_next = id3_pkg::P_DONE;
            end else if (!v2 && id_full[7:0] == id3_pkg::ID_PAD_CHAR) begin
              res        = id3_pkg::make_res(id3_pkg::K_ERR, '0, '0, '0, '0, 1'b0,
                                             version_reg, id3_pkg::E_ID);
              phase_next = id3_pkg::P_DONE;
            end else begin
              id_shift_next  = id_full;
              consumed_next  = (cons_sum[33:32] != 2'b00) ? '1 : cons_sum[31:0];
              remaining_next = size_n;
              phase_next     = id3_pkg::P_PAY;
              res            = id3_pkg::make_res(id3_pkg::K_DESC, id_full, size_n, flags_n,
                                                 '0, 1'b0, version_reg, id3_pkg::E_NONE);
            end
          end
        end
        id3_pkg::P_PAY: begin
          remaining_next = rem_dec;
          res_valid      = 1'b1;
          res            = id3_pkg::make_res(id3_pkg::K_BYTE, id_shift, size_shift, flag_shift,
                                             in_byte, (rem_dec == '0), version_reg,
                                             id3_pkg::E_NONE);
          if (rem_dec == '0) begin
            id_shift_next   = '0;
            size_shift_next = '0;
            flag_shift_next = '0;
            phase_next      = id3_pkg::P_HDR;
          end
        end
        id3_pkg::P_DONE: begin
          // bytes dropped until end of stream
        end
        default: begin
          phase_next = id3_pkg::P_DONE;
        end
      endcase
    end

    // end of stream rearms the parser
    if (in_end) begin
      phase_next       = id3_pkg::P_SIG;
      byte_index_next  = '0;
      version_reg_next = '0;
      tag_flags_next   = '0;
      tag_size_next    = '0;
      consumed_next    = '0;
      id_shift_next    = '0;
      size_shift_next  = '0;
      flag_shift_next  = '0;
      remaining_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= id3_pkg::P_SIG;
      byte_index  <= '0;
      version_reg <= '0;
      tag_flags   <= '0;
      tag_size    <= '0;
      consumed    <= '0;
      id_shift    <= '0;
      size_shift  <= '0;
      flag_shift  <= '0;
      remaining   <= '0;
    end else if (step) begin
      phase       <= phase_next;
      byte_index  <= byte_index_next;
      version_reg <= version_reg_next;
      tag_flags   <= tag_flags_next;
      tag_size    <= tag_size_next;
      consumed    <= consumed_next;
      id_shift    <= id_shift_next;
      size_shift  <= size_shift_next;
      flag_shift  <= flag_shift_next;
      remaining   <= remaining_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_end_rearms: assert property (@(posedge clk) disable iff (rst)
    step && in_end |=> phase == id3_pkg::P_SIG && byte_index == '0)
    else $error("end of stream did not rearm the parser");

  a_last_to_hdr: assert property (@(posedge clk) disable iff (rst)
    step && res_valid && res.kind == id3_pkg::K_BYTE && res.last && !in_end
    |=> phase == id3_pkg::P_HDR && byte_index == '0)
    else $error("last payload byte did not return to header walk");

  a_pay_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == id3_pkg::P_PAY |-> remaining != '0)
    else $error("payload phase with no bytes left");

  a_hdr_index: assert property (@(posedge clk) disable iff (rst)
    phase == id3_pkg::P_HDR |-> byte_index < id3_pkg::HDR_LEN_V3)
    else $error("header byte index out of range");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res.kind == id3_pkg::K_ERR) == (res.err != id3_pkg::E_NONE)))
    else $error("error code does not match result kind");
`endif

endmodule

[hw/rtl/id3v2_frame_header_parser_top.sv]
// ID3v2 frame header parser: one file byte per transaction in, frame descriptors,
// payload bytes and status results out. Depends on id3_pkg and id3_walker.
//
// The block takes one byte per clock cycle, sustained, while the result side does not
// stall it, and returns at most one result per byte. A byte is held in the input register,
// stepped through the combinational tag walker step and its result captured in the result register.
// Backpressure on the result side stalls the walker and the input register; the input side keeps
// taking bytes while the result register holds an untaken result and the input register
// is free. A byte with s_tuser set marks end of file: a tag cut short reports a truncation
// error, then the parser rearms for the next file. No clearing pass after reset.
module id3v2_frame_header_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] stream_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // [31:0] frame_id, [63:32] frame_size, [79:64] frame_flags,
                                 // [87:80] payload_byte, [90:88] major_version,
                                 // [93:91] error_code, [95:94] zero
  output logic        m_tlast,   // last_of_frame
  output logic [2:0]  m_tuser    // [2:0] result_kind
);

  logic          in_valid;
  logic [7:0]    in_byte;
  logic          in_end;
  logic          advance;
  logic          res_valid;
  id3_pkg::res_t res;
  id3_pkg::res_t out_res;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_end  <= s_tuser;
    end
  end

  id3_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .in_byte   (in_byte),
    .in_end    (in_end),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {2'b00, out_res.err, out_res.version, out_res.pbyte, out_res.flags,
                    out_res.size, out_res.id};
  assign m_tlast = out_res.last;
  assign m_tuser = out_res.kind;

endmodule

[tb/id3v2_frame_header_parser_top_tb.sv]
`timescale 1ns / 100ps
// Testbench for id3v2_frame_header_parser_top: streams generated ID3v2 files through the
// parser and checks every result against a cycle-free model of the tag walker.
// Depends on id3_pkg and the parser RTL only.
module id3v2_frame_header_parser_top_tb;

  typedef struct {
    logic [7:0] data;
    logic       eos;
    logic       drain;  // pause marker: hold the source until all results are back
  } file_item_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;
  logic        m_tlast;
  logic [2:0]  m_tuser;

  file_item_t    file_stream_q[$];
  id3_pkg::res_t frame_results_q[$];
  logic [7:0]    fbytes[$];
  logic [7:0]    tbody[$];

  int n_taken = 0;
  int n_total = 1 << 30;
  int n_seen  = 0;
  int errs    = 0;
  int src_gap = 0;
  int sink_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit src_noisy = 1'b1;
  bit sink_noisy = 1'b1;
  logic calm;

  // walker model state
  id3_pkg::phase_t ph;
  int          idx;
  logic [2:0]  ver;
  logic [7:0]  tflags;
  logic [31:0] tsize;
  logic [31:0] walked;
  logic [31:0] id_acc;
  logic [31:0] size_acc;
  logic [15:0] flag_acc;
  logic [31:0] bytes_left;

  localparam logic [7:0] ID3_SIG [3] = '{8'h49, 8'h44, 8'h33};

  assign calm = (n_taken + 150 >= n_total);

  id3v2_frame_header_parser_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- model of the tag walker ----------------

  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] c);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, c};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic reset_walker();
    ph = id3_pkg::P_SIG;
    idx = 0;
    ver = '0;
    tflags = '0;
    tsize = '0;
    walked = '0;
    id_acc = '0;
    size_acc = '0;
    flag_acc = '0;
    bytes_left = '0;
  endtask

  task automatic emit(input id3_pkg::kind_t k, input logic [31:0] id, input logic [31:0] sz,
                      input logic [15:0] fl, input logic [7:0] pb, input logic lst,
                      input id3_pkg::err_t e);
    id3_pkg::res_t r;
    r.kind = k;
    r.id = id;
    r.size = sz;
    r.flags = fl;
    r.pbyte = pb;
    r.last = lst;
    r.version = ver;
    r.err = e;
    frame_results_q.push_back(r);
  endtask

  task automatic abort_tag(input id3_pkg::err_t e);
    emit(id3_pkg::K_ERR, 32'd0, 32'd0, 16'd0, 8'd0, 1'b0, e);
    ph = id3_pkg::P_DONE;
  endtask

  task automatic walk_tag_byte(input logic [7:0] b, input logic eos);
    logic v2, v4;
    logic [7:0] mask;
    logic [31:0] fid, total;
    int idlen, hlen;
    v2 = (ver == id3_pkg::VER_MIN);
    v4 = (ver == id3_pkg::VER_MAX);
    idlen = v2 ? 3 : 4;
    hlen = v2 ? 6 : 10;

    // a frame boundary at or past the tag size ends the tag before the byte is used
    if (ph == id3_pkg::P_HDR && idx == 0 && walked >= tsize) begin
      emit(id3_pkg::K_END, 32'd0, 32'd0, 16'd0, 8'd0, 1'b0, id3_pkg::E_NONE);
      if (eos) reset_walker();
      else ph = id3_pkg::P_DONE;
      return;
    end
    if (eos) begin
      if (!(ph == id3_pkg::P_DONE || (ph == id3_pkg::P_SIG && idx == 0)))
        emit(id3_pkg::K_ERR, 32'd0, 32'd0, 16'd0, 8'd0, 1'b0, id3_pkg::E_TRUNCATED);
      reset_walker();
      return;
    end

    case (ph)
      id3_pkg::P_SIG: begin
        if (idx > 2 || b != ID3_SIG[idx]) begin
          abort_tag(id3_pkg::E_SIGNATURE);
          return;
        end
        idx++;
        if (idx == 3) begin
          ph = id3_pkg::P_VER;
          idx = 0;
        end
      end
      id3_pkg::P_VER: begin
        if (idx == 0) begin
          if (b < 8'(id3_pkg::VER_MIN) || b > 8'(id3_pkg::VER_MAX)) begin
            abort_tag(id3_pkg::E_VERSION);
            return;
          end
          ver = b[2:0];
          idx = 1;
        end else begin
          ph = id3_pkg::P_FLAGS;
          idx = 0;
        end
      end
      id3_pkg::P_FLAGS: begin
        mask = v2 ? id3_pkg::MASK_V2 : (v4 ? id3_pkg::MASK_V4 : id3_pkg::MASK_V3);
        if ((b & ~mask) != 8'd0) begin
          abort_tag(id3_pkg::E_FLAGS);
          return;
        end
        tflags = b;
        ph = id3_pkg::P_TSIZE;
        idx = 0;
      end
      id3_pkg::P_TSIZE: begin
        if (b >= id3_pkg::SYNCHSAFE_LIM) begin
          abort_tag(id3_pkg::E_SIZE);
          return;
        end
        tsize = {tsize[24:0], b[6:0]};
        idx++;
        if (idx == 4) begin
          idx = 0;
          walked = '0;
          bytes_left = '0;
          ph = ((tflags & id3_pkg::FLAG_EXTHDR) != 8'd0) ? id3_pkg::P_XSIZE : id3_pkg::P_HDR;
        end
      end
      id3_pkg::P_XSIZE: begin
        if (v4) begin
          if (b >= id3_pkg::SYNCHSAFE_LIM) begin
            abort_tag(id3_pkg::E_SIZE);
            return;
          end
          bytes_left = {bytes_left[24:0], b[6:0]};
        end else begin
          bytes_left = {bytes_left[23:0], b};
        end
        idx++;
        if (idx == 4) begin
          idx = 0;
          // 2.4 counts the size field itself, 2.3 does not
          if (v4) bytes_left = (bytes_left > 32'd4) ? bytes_left - 32'd4 : 32'd0;
          total = add_sat(bytes_left, 32'd4);
          tsize = (tsize > total) ? tsize - total : 32'd0;
          ph = (bytes_left != 0) ? id3_pkg::P_XSKIP : id3_pkg::P_HDR;
        end
      end
      id3_pkg::P_XSKIP: begin
        bytes_left = bytes_left - 32'd1;
        if (bytes_left == 0) ph = id3_pkg::P_HDR;
      end
      id3_pkg::P_HDR: begin
        if (idx < idlen) begin
          id_acc = {id_acc[23:0], b};
        end else if (idx < 2 * idlen) begin
          if (v4) begin
            if (b >= id3_pkg::SYNCHSAFE_LIM && id_acc != 0) begin
              abort_tag(id3_pkg::E_SIZE);
              return;
            end
            size_acc = {size_acc[24:0], b[6:0]};
          end else begin
            size_acc = {size_acc[23:0], b};
          end
        end else begin
          flag_acc = {flag_acc[7:0], b};
        end
        idx++;
        if (idx < hlen) return;
        idx = 0;
        if (v2) fid = (id_acc != 0) ? {id_acc[23:0], id3_pkg::ID_PAD_CHAR} : 32'd0;
        else fid = id_acc;
        // padding beats size and id checks
        if (fid == 0) begin
          emit(id3_pkg::K_PAD, 32'd0, 32'd0, 16'd0, 8'd0, 1'b0, id3_pkg::E_NONE);
          ph = id3_pkg::P_DONE;
          return;
        end
        if (size_acc == 0) begin
          abort_tag(id3_pkg::E_SIZE);
          return;
        end
        if (!v2 && fid[7:0] == id3_pkg::ID_PAD_CHAR) begin
          abort_tag(id3_pkg::E_ID);
          return;
        end
        id_acc = fid;
        walked = add_sat(add_sat(walked, 32'(hlen)), size_acc);
        bytes_left = size_acc;
        ph = id3_pkg::P_PAY;
        emit(id3_pkg::K_DESC, id_acc, size_acc, flag_acc, 8'd0, 1'b0, id3_pkg::E_NONE);
      end
      id3_pkg::P_PAY: begin
        bytes_left = bytes_left - 32'd1;
        emit(id3_pkg::K_BYTE, id_acc, size_acc, flag_acc, b, bytes_left == 0,
             id3_pkg::E_NONE);
        if (bytes_left == 0) begin
          id_acc = '0;
          size_acc = '0;
          flag_acc = '0;
          ph = id3_pkg::P_HDR;
        end
      end
      default: ;
    endcase
  endtask

  // ---------------- file generation ----------------

  task automatic queue_byte(input logic [7:0] d, input logic eos, input logic drain);
    file_item_t it;
    it.data = d;
    it.eos = eos;
    it.drain = drain;
    file_stream_q.push_back(it);
  endtask

  function automatic logic [7:0] id_char();
    int r;
    r = $urandom_range(0, 35);
    return (r < 26) ? 8'(8'h41 + r) : 8'(8'h30 + r - 26);
  endfunction

  // big-endian, 7 bits per byte when synchsafe
  task automatic push_word(input logic [31:0] w, input int nb, input bit sync7,
                           input bit to_head);
    logic [7:0] v;
    for (int i = nb - 1; i >= 0; i--) begin
      v = sync7 ? {1'b0, w[7*i +: 7]} : w[8*i +: 8];
      if (to_head) fbytes.push_back(v);
      else tbody.push_back(v);
    end
  endtask

  task automatic build_tag();
    int vnum, idlen, hlen, nfr, psize, sel, xskip, padn, k;
    logic [7:0] mask, flags;
    logic [31:0] tsz, xval;
    logic [7:0] fid [4];
    vnum = $urandom_range(2, 4);
    idlen = (vnum == 2) ? 3 : 4;
    hlen = (vnum == 2) ? 6 : 10;
    mask = (vnum == 2) ? id3_pkg::MASK_V2
                       : ((vnum == 4) ? id3_pkg::MASK_V4 : id3_pkg::MASK_V3);
    flags = 8'($urandom) & mask;
    tbody.delete();
    fbytes.delete();
    if ((flags & id3_pkg::FLAG_EXTHDR) != 8'd0) begin
      xskip = $urandom_range(0, 10);
      if (vnum == 4) begin
        xval = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 32'(xskip + 4);
        if (xval < 4) xskip = 0;
        push_word(xval, 4, 1'b1, 1'b0);
      end else begin
        push_word(32'(xskip), 4, 1'b0, 1'b0);
      end
      repeat (xskip) tbody.push_back(8'($urandom));
    end
    tsz = tbody.size();
    nfr = $urandom_range(0, 4);
    repeat (nfr) begin
      psize = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      sel = $urandom_range(0, 39);
      if (sel == 0) psize = 0;
      for (int i = 0; i < 4; i++) fid[i] = (sel == 2) ? 8'h00 : id_char();
      if (sel == 1) fid[idlen-1] = id3_pkg::ID_PAD_CHAR;
      for (int i = 0; i < idlen; i++) tbody.push_back(fid[i]);
      push_word(32'(psize), idlen, vnum == 4, 1'b0);
      // bad synchsafe size byte; with a zero id it must still read as padding
      if ((sel == 2 || sel == 3) && vnum == 4) begin
        k = tbody.size() - 1 - $urandom_range(0, 3);
        tbody[k] = tbody[k] | 8'h80;
      end
      if (vnum != 2) begin
        tbody.push_back(8'($urandom));
        tbody.push_back(8'($urandom));
      end
      repeat (psize) tbody.push_back(8'($urandom));
      tsz += 32'(hlen + psize);
    end
    if ($urandom_range(0, 9) < 4) begin
      padn = hlen + $urandom_range(0, 4);
      repeat (padn) tbody.push_back(8'h00);
      tsz += 32'(padn);
    end
    if ($urandom_range(0, 6) == 0) tsz = $urandom_range(0, tsz + 20);
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 4)) tbody.push_back(8'($urandom));
    for (int i = 0; i < 3; i++) fbytes.push_back(ID3_SIG[i]);
    fbytes.push_back(8'(vnum));
    fbytes.push_back(8'($urandom));
    fbytes.push_back(flags);
    push_word(tsz, 4, 1'b1, 1'b1);
    foreach (tbody[i]) fbytes.push_back(tbody[i]);
  endtask

  // sizes at their maximum, cut short by end of file
  task automatic build_huge();
    int vnum;
    bit ext;
    vnum = $urandom_range(2, 4);
    ext = (vnum != 2) && ($urandom_range(0, 1) == 1);
    fbytes.delete();
    for (int i = 0; i < 3; i++) fbytes.push_back(ID3_SIG[i]);
    fbytes.push_back(8'(vnum));
    fbytes.push_back(8'hFF);
    fbytes.push_back(ext ? id3_pkg::FLAG_EXTHDR : 8'h00);
    repeat (4) fbytes.push_back(8'h7F);
    if (ext) begin
      repeat (4) fbytes.push_back((vnum == 4) ? 8'h7F : 8'hFF);
    end else begin
      repeat ((vnum == 2) ? 3 : 4) fbytes.push_back(id_char());
      repeat ((vnum == 2) ? 3 : 4) fbytes.push_back((vnum == 4) ? 8'h7F : 8'hFF);
      if (vnum != 2) repeat (2) fbytes.push_back(8'hFF);
    end
    repeat ($urandom_range(3, 8)) fbytes.push_back(8'($urandom));
  endtask

  // how: 0 as built, 1 one byte corrupted, 2 cut short
  task automatic commit_file(input int how);
    int pos;
    if (how == 1 && fbytes.size() > 0) begin
      pos = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 9) : $urandom_range(0, 999);
      pos = pos % fbytes.size();
      case ($urandom_range(0, 2))
        0: fbytes[pos] = 8'($urandom);
        1: fbytes[pos] = fbytes[pos] ^ 8'h80;
        default: fbytes[pos] = fbytes[pos] ^ (8'h01 << $urandom_range(0, 7));
      endcase
    end
    if (how == 2 && fbytes.size() > 1) begin
      pos = $urandom_range(1, fbytes.size() - 1);
      while (fbytes.size() > pos) void'(fbytes.pop_back());
    end
    foreach (fbytes[i]) queue_byte(fbytes[i], 1'b0, 1'b0);
    queue_byte(8'($urandom), 1'b1, 1'b0);
  endtask

  // ---------------- source side ----------------

  always @(posedge clk) begin
    logic nv, nu;
    logic [7:0] nd;
    file_item_t it;
    nv = s_tvalid;
    nd = s_tdata;
    nu = s_tuser;
    if (rst) begin
      nv = 1'b0;
      nd = 8'h00;
      nu = 1'b0;
      src_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        walk_tag_byte(s_tdata, s_tuser);
        n_taken++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (file_stream_q.size() > 0) begin
          if (file_stream_q[0].drain) begin
            if (frame_results_q.size() == 0) void'(file_stream_q.pop_front());
          end else if (!calm && src_noisy && $urandom_range(0, 7) == 0) begin
            src_gap = $urandom_range(0, 14);
          end else begin
            it = file_stream_q.pop_front();
            nv = 1'b1;
            nd = it.data;
            nu = it.eos;
            if ($urandom_range(0, 149) == 0) src_noisy = ~src_noisy;
          end
        end
      end
    end
    s_tvalid <= nv;
    s_tdata <= nd;
    s_tuser <= nu;
  end

  // ---------------- result side ----------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errs++;
    $display("mismatch at result %0d: %s got %0h want %0h", n_seen, what, got, want);
  endtask

  task automatic check_result();
    id3_pkg::res_t w;
    n_seen++;
    if (frame_results_q.size() == 0) begin
      report_mismatch("result with nothing pending, kind", 32'(m_tuser), 32'd0);
      return;
    end
    w = frame_results_q.pop_front();
    if (m_tuser !== w.kind) report_mismatch("result_kind", 32'(m_tuser), 32'(w.kind));
    if (m_tdata[31:0] !== w.id) report_mismatch("frame_id", m_tdata[31:0], w.id);
    if (m_tdata[63:32] !== w.size) report_mismatch("frame_size", m_tdata[63:32], w.size);
    if (m_tdata[79:64] !== w.flags)
      report_mismatch("frame_flags", 32'(m_tdata[79:64]), 32'(w.flags));
    if (m_tdata[87:80] !== w.pbyte)
      report_mismatch("payload_byte", 32'(m_tdata[87:80]), 32'(w.pbyte));
    if (m_tlast !== w.last) report_mismatch("last_of_frame", 32'(m_tlast), 32'(w.last));
    if (m_tdata[90:88] !== w.version)
      report_mismatch("major_version", 32'(m_tdata[90:88]), 32'(w.version));
    if (m_tdata[93:91] !== w.err)
      report_mismatch("error_code", 32'(m_tdata[93:91]), 32'(w.err));
  endtask

  always @(posedge clk) begin
    logic nr;
    nr = m_tready;
    if (rst) begin
      nr = 1'b0;
      sink_gap = 0;
    end else begin
      if (m_tvalid && m_tready) check_result();
      if ($urandom_range(0, 199) == 0) sink_noisy = ~sink_noisy;
      if (hold_left > 0) begin
        // long hold-off so the parser backs up into its input
        hold_left--;
        nr = 1'b0;
      end else if (!hold_done && n_taken >= 400 && m_tvalid) begin
        hold_done = 1'b1;
        hold_left = 299;
        nr = 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        nr = 1'b0;
      end else if (!calm && sink_noisy && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 14);
        nr = 1'b0;
      end else begin
        nr = 1'b1;
      end
    end
    m_tready <= nr;
  end

  // ---------------- sequence ----------------

  initial begin
    int r, guard;
    reset_walker();

    // end of file while idle: nothing
    queue_byte(8'h00, 1'b1, 1'b0);
    // bad signature on an all-ones byte
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'hA5, 1'b1, 1'b0);
    // unsupported version
    for (int i = 0; i < 3; i++) queue_byte(ID3_SIG[i], 1'b0, 1'b0);
    queue_byte(8'h05, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b1, 1'b0);
    // minimal 2.2 tag: one frame of one byte, then tag end on the end-of-file item
    for (int i = 0; i < 3; i++) queue_byte(ID3_SIG[i], 1'b0, 1'b0);
    queue_byte(8'h02, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h07, 1'b0, 1'b0);
    queue_byte(8'h54, 1'b0, 1'b0);
    queue_byte(8'h54, 1'b0, 1'b0);
    queue_byte(8'h32, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h01, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b1, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b1);

    while (file_stream_q.size() < 1330) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        build_huge();
        commit_file(0);
      end else if (r < 8) begin
        fbytes.delete();
        repeat ($urandom_range(1, 8)) fbytes.push_back(8'($urandom));
        commit_file(0);
      end else begin
        build_tag();
        commit_file((r < 70) ? 0 : ((r < 87) ? 1 : 2));
      end
      if ($urandom_range(0, 29) == 0) queue_byte(8'h00, 1'b0, 1'b1);
    end
    n_total = file_stream_q.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (file_stream_q.size() != 0 || s_tvalid) @(posedge clk);
    guard = 0;
    while (frame_results_q.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (frame_results_q.size() != 0)
      report_mismatch("results never delivered, count", 32'(frame_results_q.size()), 32'd0);
    if (errs == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
